@@ rtl/laplacian_stencil_2d_core_defines.svh @@
// Assertion macros shared by the Laplacian stencil RTL.
`ifndef LAPLACIAN_STENCIL_2D_CORE_DEFINES_SVH
`define LAPLACIAN_STENCIL_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LAP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lap_pkg.sv @@
// Shared constants and types for the Laplacian stencil core.
package lap_pkg;

    localparam int COLS           = 64;
    localparam int ROWS           = 16;
    localparam int COL_W          = $clog2(COLS);
    localparam int ROW_W          = $clog2(ROWS);

    localparam int SAMPLE_W       = 16;
    localparam int WEIGHT_W       = 16;
    localparam int LAP_W          = 36;
    localparam int CELL_ROW_W     = 4;
    localparam int CELL_COL_W     = 6;
    localparam int TERM_W         = SAMPLE_W + 2;
    localparam int PROD_W         = TERM_W + WEIGHT_W + 1;

    localparam int STORE_DEPTH    = 3 * COLS;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int SLOT_W         = 2;

    localparam int RES_PER_ITEM   = 3;
    localparam int RES_IDX_W      = $clog2(RES_PER_ITEM + 1);

    localparam int QDEPTH         = 4;
    localparam int Q_PTR_W        = $clog2(QDEPTH);
    localparam int Q_CNT_W        = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_X_RESET = 16'd3969;
    localparam logic [WEIGHT_W-1:0] WEIGHT_Y_RESET = 16'd225;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_X = 2'd0,
        REG_WEIGHT_Y = 2'd1
    } cfg_reg_e;

    // One result to compute: xt * weight_x + yt * weight_y.
    typedef struct packed {
        logic signed [TERM_W-1:0] xt;
        logic signed [TERM_W-1:0] yt;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
    } cell_op_t;

    // All results caused by one sample; valid ones form a prefix of length n.
    typedef struct packed {
        logic [RES_IDX_W-1:0]              n;
        cell_op_t [RES_PER_ITEM-1:0]       op;
    } job_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

@@ rtl/lap_ifaces.sv @@
// Channel interfaces: sample input, result output and register writes.
interface lap_sample_if import lap_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lap_result_if import lap_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [LAP_W-1:0]  lap_value;
    logic [CELL_ROW_W-1:0]    cell_row;
    logic [CELL_COL_W-1:0]    cell_col;
    logic                     frame_last;

    modport source (output valid, output lap_value, output cell_row, output cell_col,
                    output frame_last, input ready);
    modport sink   (input valid, input lap_value, input cell_row, input cell_col,
                    input frame_last, output ready);
endinterface

interface lap_cfg_if import lap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lap_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module lap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ rtl/lap_front.sv @@
// Front end: raster counters, line store, neighbour window and job building.
module lap_front import lap_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    lap_sample_if.sink     samples,
    input  q_status_t      q_status,
    output logic           q_push,
    output job_t           q_job
);

    logic [ROW_W-1:0]           row_reg, row_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic                       s1_v_reg;
    logic [ROW_W-1:0]           s1_row_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [SAMPLE_W-1:0] win_e_reg;
    logic signed [SAMPLE_W-1:0] win_c_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;

    logic                       accept;
    logic                       s1_leave;
    logic [SLOT_W-1:0]          slot_prev;
    logic [SLOT_W-1:0]          slot_prev2;
    logic [COL_W-1:0]           col_east;
    logic [STORE_AW-1:0]        wr_addr;
    logic [STORE_AW-1:0]        rd_addr_a;
    logic [STORE_AW-1:0]        rd_addr_b;
    logic [SAMPLE_W-1:0]        rd_data_a;
    logic [SAMPLE_W-1:0]        rd_data_b;

    logic signed [SAMPLE_W-1:0] c16;
    logic signed [TERM_W-1:0]   t_s, t_e, t_c, t_w, t_n, t_p;

    assign accept        = samples.valid && samples.ready;
    assign samples.ready = !s1_v_reg || !q_status.full;
    assign s1_leave      = s1_v_reg && !q_status.full;

    // Row r lives in slot r mod 3; r-2 shares its residue with r+1.
    assign slot_prev  = (slot_reg == SLOT_W'(0)) ? SLOT_W'(2) : slot_reg - 1'b1;
    assign slot_prev2 = (slot_reg == SLOT_W'(2)) ? SLOT_W'(0) : slot_reg + 1'b1;
    assign col_east   = (col_reg == COL_W'(COLS - 1)) ? '0 : col_reg + 1'b1;

    assign wr_addr   = STORE_AW'(int'(slot_reg) * COLS + int'(col_reg));
    assign rd_addr_a = STORE_AW'(int'(slot_prev) * COLS + int'(col_east));
    // Column 0 needs no north sample, so port B fetches the centre instead.
    assign rd_addr_b = (col_reg == '0) ? STORE_AW'(int'(slot_prev) * COLS)
                                       : STORE_AW'(int'(slot_prev2) * COLS + int'(col_reg));

    lap_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (wr_addr),
        .wr_data   (samples.sample),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (col_reg == COL_W'(COLS - 1))
            begin
                col_next  = '0;
                slot_next = (slot_reg == SLOT_W'(2)) ? '0 : slot_reg + 1'b1;
                row_next  = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Window over row r-1: W, C from earlier reads, E from this read.
    assign c16 = (s1_col_reg == '0) ? $signed(rd_data_b) : win_e_reg;
    assign t_s = TERM_W'(s1_sample_reg);
    assign t_e = TERM_W'($signed(rd_data_a));
    assign t_c = TERM_W'(c16);
    assign t_w = TERM_W'(win_c_reg);
    assign t_n = TERM_W'($signed(rd_data_b));
    assign t_p = TERM_W'(prev_reg);

    always_comb
    begin
        q_job = '0;

        // Cell one row above the incoming sample.
        q_job.op[0].row  = s1_row_reg - 1'b1;
        q_job.op[0].col  = s1_col_reg;
        q_job.op[0].last = 1'b0;
        priority if (s1_col_reg == '0)
        begin
            q_job.op[0].xt = t_e - (t_c <<< 1);
        end
        else if (s1_col_reg == COL_W'(COLS - 1))
        begin
            q_job.op[0].xt = t_w - (t_c <<< 1);
        end
        else if (s1_row_reg == ROW_W'(1))
        begin
            q_job.op[0].yt = t_s - (t_c <<< 1);
        end
        else
        begin
            q_job.op[0].xt = t_w + t_e - (t_c <<< 1);
            q_job.op[0].yt = t_n + t_s - (t_c <<< 1);
        end

        // Bottom row: the cell left of the incoming sample.
        q_job.op[1].row  = s1_row_reg;
        q_job.op[1].col  = s1_col_reg - 1'b1;
        q_job.op[1].last = 1'b0;
        if (s1_col_reg == COL_W'(1))
        begin
            q_job.op[1].xt = t_s - (t_p <<< 1);
        end
        else
        begin
            q_job.op[1].yt = t_w - (t_p <<< 1);
        end

        // Bottom right corner closes the grid.
        q_job.op[2].row  = s1_row_reg;
        q_job.op[2].col  = s1_col_reg;
        q_job.op[2].last = 1'b1;
        q_job.op[2].xt   = t_p - (t_s <<< 1);

        if (s1_row_reg != ROW_W'(ROWS - 1))
        begin
            q_job.n = RES_IDX_W'(1);
        end
        else if (s1_col_reg == COL_W'(COLS - 1))
        begin
            q_job.n = RES_IDX_W'(3);
        end
        else if (s1_col_reg != '0)
        begin
            q_job.n = RES_IDX_W'(2);
        end
        else
        begin
            q_job.n = RES_IDX_W'(1);
        end
    end

    // Top row samples produce nothing.
    assign q_push = s1_leave && (s1_row_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
            s1_v_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
            if (accept)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_leave)
            begin
                s1_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_sample_reg <= samples.sample;
        end
        if (s1_leave)
        begin
            win_e_reg <= $signed(rd_data_a);
            win_c_reg <= c16;
            prev_reg  <= s1_sample_reg;
        end
    end

endmodule

@@ rtl/lap_queue.sv @@
// Job queue between the front end and the arithmetic back end.
module lap_queue import lap_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t status
);

    job_t               mem_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(QDEPTH));
    assign status.avail = (count_reg != '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.avail;
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/lap_back.sv @@
// Back end: walks each job's results through multiply, add and output stages.
module lap_back import lap_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  q_status_t           q_status,
    input  job_t                q_job,
    output logic                q_pop,
    input  logic [WEIGHT_W-1:0] weight_x,
    input  logic [WEIGHT_W-1:0] weight_y,
    lap_result_if.source        results
);

    job_t                      job_reg;
    logic                      job_v_reg;
    logic [RES_IDX_W-1:0]      idx_reg;
    logic                      m_v_reg;
    cell_op_t                  m_op_reg;
    logic                      p_v_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic [ROW_W-1:0]          p_row_reg;
    logic [COL_W-1:0]          p_col_reg;
    logic                      p_last_reg;
    logic                      out_v_reg;
    logic signed [LAP_W-1:0]   lap_reg;
    logic [CELL_ROW_W-1:0]     row_reg;
    logic [CELL_COL_W-1:0]     col_reg;
    logic                      last_reg;

    logic out_free, p_go, p_free, m_go, m_free, issue, job_done, job_free;

    assign out_free = !out_v_reg || results.ready;
    assign p_go     = p_v_reg && out_free;
    assign p_free   = !p_v_reg || out_free;
    assign m_go     = m_v_reg && p_free;
    assign m_free   = !m_v_reg || p_free;
    assign issue    = job_v_reg && m_free;
    assign job_done = (idx_reg == job_reg.n - 1'b1);
    assign job_free = !job_v_reg || (issue && job_done);
    assign q_pop    = q_status.avail && job_free;

    assign results.valid      = out_v_reg;
    assign results.lap_value  = lap_reg;
    assign results.cell_row   = row_reg;
    assign results.cell_col   = col_reg;
    assign results.frame_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_v_reg <= 1'b0;
            idx_reg   <= '0;
            m_v_reg   <= 1'b0;
            p_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_v_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (issue)
            begin
                if (job_done)
                begin
                    job_v_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (issue)
            begin
                m_v_reg <= 1'b1;
            end
            else if (m_go)
            begin
                m_v_reg <= 1'b0;
            end

            if (m_go)
            begin
                p_v_reg <= 1'b1;
            end
            else if (p_go)
            begin
                p_v_reg <= 1'b0;
            end

            if (p_go)
            begin
                out_v_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (issue)
        begin
            m_op_reg <= job_reg.op[idx_reg];
        end
        if (m_go)
        begin
            px_reg     <= PROD_W'(m_op_reg.xt) * PROD_W'($signed({1'b0, weight_x}));
            py_reg     <= PROD_W'(m_op_reg.yt) * PROD_W'($signed({1'b0, weight_y}));
            p_row_reg  <= m_op_reg.row;
            p_col_reg  <= m_op_reg.col;
            p_last_reg <= m_op_reg.last;
        end
        if (p_go)
        begin
            lap_reg  <= LAP_W'(px_reg) + LAP_W'(py_reg);
            row_reg  <= CELL_ROW_W'(p_row_reg);
            col_reg  <= CELL_COL_W'(p_col_reg);
            last_reg <= p_last_reg;
        end
    end

endmodule

@@ rtl/laplacian_stencil_2d_core.sv @@
// A result passes the front-end, job queue, job, operand, product and sum registers.
// Throughput: one sample per cycle; the single multiply-add lane gives one result
// per cycle while results.ready is high, so bottom-row samples (two results each,
// one at column 0, three for the last) stall the input once the 4-entry job queue fills.
// Reset: clears raster position, pipeline and queue; weights return to 3969 and 225.
// The line store is not cleared; values read from unwritten entries are never used.
`include "laplacian_stencil_2d_core_defines.svh"

module laplacian_stencil_2d_core import lap_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    lap_sample_if.sink    samples,
    lap_result_if.source  results,
    lap_cfg_if.sink       cfg
);

    logic [WEIGHT_W-1:0] weight_x_reg;
    logic [WEIGHT_W-1:0] weight_y_reg;
    logic                q_push;
    logic                q_pop;
    job_t                push_job;
    job_t                pop_job;
    q_status_t           q_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_x_reg <= WEIGHT_X_RESET;
            weight_y_reg <= WEIGHT_Y_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_WEIGHT_X:
                begin
                    weight_x_reg <= WEIGHT_W'(cfg.data);
                end
                REG_WEIGHT_Y:
                begin
                    weight_y_reg <= WEIGHT_W'(cfg.data);
                end
                default:
                begin
                end
            endcase
        end
    end

    lap_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    lap_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    lap_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .weight_x (weight_x_reg),
        .weight_y (weight_y_reg),
        .results  (results)
    );

    `LAP_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, !q_status.full, "job pushed into full queue")
    `LAP_ASSERT_IMP(a_job_nonempty, clk, rst_n, q_push, push_job.n != '0, "job with no results")
    `LAP_ASSERT_NXT(a_push_visible, clk, rst_n, q_push, q_status.avail, "pushed job not visible")
    `LAP_ASSERT_IMP(a_last_corner, clk, rst_n, results.valid && results.frame_last,
        results.cell_row == CELL_ROW_W'(ROWS - 1) && results.cell_col == CELL_COL_W'(COLS - 1),
        "frame end flagged away from the last cell")

endmodule

@@ verif/lap_tb_pkg.sv @@
// Scoreboard for the Laplacian stencil core: raster-order predictor and result checker.
package lap_tb_pkg;
    import lap_pkg::*;

    typedef struct {
        logic signed [LAP_W-1:0] lap_value;
        logic [CELL_ROW_W-1:0]   cell_row;
        logic [CELL_COL_W-1:0]   cell_col;
        logic                    frame_last;
    } cell_result_t;

    class stencil_scoreboard;
        logic signed [SAMPLE_W-1:0] line_rows [3][COLS];
        int unsigned                row_pos;
        int unsigned                col_pos;
        logic [WEIGHT_W-1:0]        weight_x;
        logic [WEIGHT_W-1:0]        weight_y;
        cell_result_t               pending_cells [$];
        int                         errors;

        function new();
            foreach (line_rows[i, j])
            begin
                line_rows[i][j] = '0;
            end
            row_pos  = 0;
            col_pos  = 0;
            weight_x = WEIGHT_X_RESET;
            weight_y = WEIGHT_Y_RESET;
            errors   = 0;
        endfunction

        // Spare indexes are accepted by the port but change nothing.
        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_WEIGHT_X: weight_x = data;
                REG_WEIGHT_Y: weight_y = data;
                default: ;
            endcase
        endfunction

        function longint px(int unsigned r, int unsigned c);
            return longint'(line_rows[r % 3][c]);
        endfunction

        function longint cell_laplacian(int unsigned r, int unsigned c);
            longint xt;
            longint yt;
            longint wx;
            longint wy;
            wx = longint'(weight_x);
            wy = longint'(weight_y);
            // edge columns win over edge rows, so corners take the x term only
            if (c == 0)
                return (px(r, 1) - 2 * px(r, 0)) * wx;
            if (c == COLS - 1)
                return (px(r, COLS - 2) - 2 * px(r, COLS - 1)) * wx;
            if (r == 0)
                return (px(1, c) - 2 * px(0, c)) * wy;
            if (r == ROWS - 1)
                return (px(ROWS - 2, c) - 2 * px(ROWS - 1, c)) * wy;
            xt = px(r, c - 1) + px(r, c + 1) - 2 * px(r, c);
            yt = px(r - 1, c) + px(r + 1, c) - 2 * px(r, c);
            return xt * wx + yt * wy;
        endfunction

        function void queue_cell(int unsigned r, int unsigned c, bit last);
            cell_result_t e;
            e.lap_value  = LAP_W'(cell_laplacian(r, c));
            e.cell_row   = CELL_ROW_W'(r);
            e.cell_col   = CELL_COL_W'(c);
            e.frame_last = last;
            pending_cells.push_back(e);
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned r;
            int unsigned c;
            r = row_pos;
            c = col_pos;
            line_rows[r % 3][c] = s;
            if (r >= 1)
                queue_cell(r - 1, c, 1'b0);
            // bottom row trails by one column and flushes its last cell at the end
            if (r == ROWS - 1)
            begin
                if (c >= 1)
                    queue_cell(r, c - 1, 1'b0);
                if (c == COLS - 1)
                    queue_cell(r, c, 1'b1);
            end
            col_pos = c + 1;
            if (col_pos >= COLS)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= ROWS) ? 0 : r + 1;
            end
        endfunction

        function void check_result(cell_result_t got);
            cell_result_t want;
            if (pending_cells.size() == 0)
            begin
                $error("result with nothing expected: row %0d col %0d value %0d",
                       got.cell_row, got.cell_col, got.lap_value);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            if (got.lap_value !== want.lap_value)
            begin
                $error("lap_value: expected %0d, got %0d", want.lap_value, got.lap_value);
                errors++;
            end
            if (got.cell_row !== want.cell_row)
            begin
                $error("cell_row: expected %0d, got %0d", want.cell_row, got.cell_row);
                errors++;
            end
            if (got.cell_col !== want.cell_col)
            begin
                $error("cell_col: expected %0d, got %0d", want.cell_col, got.cell_col);
                errors++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

endpackage

@@ verif/laplacian_stencil_2d_core_test.sv @@
// Top-level testbench for laplacian_stencil_2d_core: stimulus, back-pressure and checking.
module laplacian_stencil_2d_core_test import lap_pkg::*, lap_tb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASE_LEN    = 52;
    localparam int     TAIL_LEN     = 50;
    localparam int     N_PHASES     = 6;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     HOLD_CYCLES  = 300;
    localparam longint CYCLE_LIMIT  = 1000000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam logic [WEIGHT_W-1:0]        W_MAX = 16'hFFFF;
    localparam logic [WEIGHT_W-1:0]        W_ZERO = 16'h0000;

    localparam logic signed [SAMPLE_W-1:0] DIRECTED [24] = '{
        S_MAX, S_MIN, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000, 16'shC000, S_MAX,
        S_MAX, S_MIN, S_MIN, 16'sh0000, S_MAX, 16'sh0000, S_MIN, 16'sh5555,
        16'shAAAA, 16'sh0001, 16'sh7FFE, 16'sh8001, S_MIN, S_MAX, S_MIN, S_MAX
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    longint cycle_count = 0;
    int     results_seen = 0;
    int     samples_sent = 0;

    stencil_scoreboard sb;

    lap_sample_if smp_ch ();
    lap_result_if res_ch ();
    lap_cfg_if    cfg_ch ();

    laplacian_stencil_2d_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        cell_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.lap_value  = res_ch.lap_value;
            got.cell_row   = res_ch.cell_row;
            got.cell_col   = res_ch.cell_col;
            got.frame_last = res_ch.frame_last;
            sb.check_result(got);
            results_seen <= results_seen + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_run();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        if (roll < 90)
            return $urandom_range(9, 30);
        return $urandom_range(50, 150);
    endfunction

    function automatic int pick_stall();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Result sink: random ready pattern, plus two long hold-offs to back the queue up.
    initial
    begin
        int run;
        int stall;
        int hold_at [$];
        hold_at.push_back(100);
        hold_at.push_back(180);
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run   = pick_run();
            stall = pick_stall();
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            // only hold off while the sender is offering, so the input really stalls
            if (hold_at.size() > 0 && results_seen >= hold_at[0] && smp_ch.valid)
            begin
                void'(hold_at.pop_front());
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input int gap);
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        sb.note_sample(value);
        samples_sent++;
        if (gap > 0)
        begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // keep_valid avoids dropping and re-raising valid within one step on back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(index, data);
        if (!keep_valid)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_weights(input logic [WEIGHT_W-1:0] wx, input logic [WEIGHT_W-1:0] wy,
                               input bit spare);
        if (spare)
        begin
            cfg_write(REG_SPARE_2, CFG_DATA_W'($urandom), 1'b1);
            cfg_write(REG_SPARE_3, CFG_DATA_W'($urandom), 1'b1);
        end
        cfg_write(REG_WEIGHT_X, wx, 1'b1);
        cfg_write(REG_WEIGHT_Y, wy, 1'b0);
    endtask

    // Row-0 samples produce nothing, so allow the pipeline to settle after the queue empties.
    task automatic wait_drained();
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit directed);
        int                         k;
        int                         row;
        int                         col;
        int                         mode;
        bit                         calm;
        bit                         flip;
        logic signed [SAMPLE_W-1:0] value;
        for (k = 0; k < count; k++)
        begin
            col = samples_sent % COLS;
            row = (samples_sent / COLS) % ROWS;
            // pattern and pacing change per row and at the start of each phase
            if (col == 0 || k == 0)
            begin
                mode = $urandom_range(0, 3);
                calm = ($urandom_range(0, 3) == 0);
                flip = $urandom_range(0, 1);
            end
            if (directed && k < $size(DIRECTED))
                value = DIRECTED[k];
            else
                case (mode)
                    2: value = (((row + col) % 2) ^ flip) ? S_MAX : S_MIN;
                    3:
                    begin
                        case ($urandom_range(0, 4))
                            0: value = S_MAX;
                            1: value = S_MIN;
                            2: value = 16'sh0000;
                            3: value = 16'shFFFF;
                            default: value = 16'sh0001;
                        endcase
                    end
                    default: value = SAMPLE_W'($urandom);
                endcase
            send_sample(value, calm ? 0 : pick_gap());
        end
        smp_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int p;
        sb = new();
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_WEIGHT_X;
        cfg_ch.data   <= '0;
        rst_n         <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Five phases of 52 samples and a short tail: about 310 samples over the first rows.
        for (p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                case (p)
                    1: set_weights(W_MAX, W_MAX, 1'b1);
                    2: set_weights(W_ZERO, W_ZERO, 1'b0);
                    3: set_weights(16'd1, W_MAX, 1'b0);
                    4: set_weights(W_MAX, W_ZERO, 1'b1);
                    default: set_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom), 1'b0);
                endcase
            end
            run_phase((p == N_PHASES - 1) ? TAIL_LEN : PHASE_LEN, p == 0);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
